// ===== rtl/core/rrs_pkg.sv =====
package rrs_pkg;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WINDOW_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_W-1:0] WINDOW_HEIGHT_RST = 13'd1080;

    // payload widths
    localparam int FIELD_W = 12;
    localparam int COLOR_W = 32;
    localparam int COL_W   = 13;
    localparam int ADDR_W  = 25;

    // scaling: a 13-bit virtual coordinate times a 13-bit window size
    localparam int NUM_W  = 13;
    localparam int PROD_W = 26;

    localparam logic [COL_W-1:0] COL_MAX = '1;

endpackage

// ===== rtl/core/rect_row_span_rasterizer_top.sv =====
// Channel | Dir | Handshake             | Payload
// cfg     | in  | cfg_we                | cfg_index, cfg_data
// in      | in  | in_valid / in_ready   | rect_x rect_y rect_w rect_h filled thickness row color
// out     | out | out_valid / out_ready | span_start span_end start_address span_valid
//         |     |                       | pixel_color last_span
//
// One row request per clock while the result register can load; an outline middle row holds
// the output register for two transfers, and no new request is taken until its second span goes.
// Each input transfer passes through the product, reciprocal estimate and correction registers,
// then the span/result register.
// The whole pipeline advances together whenever the result register can load.
// rst_n clears the valid bits and the output selector and restores the window size.
module rect_row_span_rasterizer_top
    import rrs_pkg::*;
#(
    parameter int VIRT_W = 1920,
    parameter int VIRT_H = 1080
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FIELD_W-1:0]   rect_x,
    input  logic [FIELD_W-1:0]   rect_y,
    input  logic [FIELD_W-1:0]   rect_w,
    input  logic [FIELD_W-1:0]   rect_h,
    input  logic                 filled,
    input  logic [FIELD_W-1:0]   thickness,
    input  logic [FIELD_W-1:0]   row,
    input  logic [COLOR_W-1:0]   color,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COL_W-1:0]     span_start,
    output logic [COL_W-1:0]     span_end,
    output logic [ADDR_W-1:0]    start_address,
    output logic                 span_valid,
    output logic [COLOR_W-1:0]   pixel_color,
    output logic                 last_span
);

    localparam int SW = PROD_W + 2;

    logic [CFG_W-1:0] win_w_reg;
    logic [CFG_W-1:0] win_h_reg;

    logic pipe_en;

    // side pipeline
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic               s1_filled_reg, s2_filled_reg, s3_filled_reg;
    logic [FIELD_W-1:0] s1_thick_reg, s2_thick_reg, s3_thick_reg;
    logic [FIELD_W-1:0] s1_row_reg, s2_row_reg, s3_row_reg;
    logic [COLOR_W-1:0] s1_color_reg, s2_color_reg, s3_color_reg;
    logic [ADDR_W-1:0]  s1_roww_reg, s2_roww_reg, s3_roww_reg;
    logic [ADDR_W-1:0]  roww_next;

    logic [NUM_W-1:0]  nx1, nx2, ny1, ny2;
    logic [PROD_W-1:0] qx1, qx2, qy1, qy2;

    // span decision
    logic                hit_next;
    logic                two_next;
    logic signed [SW-1:0] a_s, a_e, b_s, b_e;
    logic [COL_W-1:0]    a_start_next, a_end_next, b_start_next, b_end_next;
    logic [ADDR_W-1:0]   a_addr_next, b_addr_next;
    logic [COLOR_W-1:0]  color_next;

    // result register
    logic               out_valid_reg;
    logic               two_reg;
    logic               sel_reg;
    logic               hit_reg;
    logic [COL_W-1:0]   a_start_reg, a_end_reg, b_start_reg, b_end_reg;
    logic [ADDR_W-1:0]  a_addr_reg, b_addr_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               on_last;

    function automatic logic [COL_W-1:0] sat_col(input logic signed [SW-1:0] v);
        logic [COL_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(SW'(COL_MAX)))
            r = COL_MAX;
        else
            r = v[COL_W-1:0];
        return r;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= WINDOW_WIDTH_RST;
            win_h_reg <= WINDOW_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_WIDTH:  win_w_reg <= cfg_data;
                REG_WINDOW_HEIGHT: win_h_reg <= cfg_data;
            endcase
        end
    end

    // corner scaling
    assign nx1 = NUM_W'(rect_x);
    assign nx2 = NUM_W'(rect_x) + NUM_W'(rect_w);
    assign ny1 = NUM_W'(rect_y);
    assign ny2 = NUM_W'(rect_y) + NUM_W'(rect_h);

    rrs_scale #(.DIVISOR(VIRT_W)) u_scale_x1
    (
        .clk   (clk),
        .en    (pipe_en),
        .num   (nx1),
        .scale (win_w_reg),
        .quo   (qx1)
    );

    rrs_scale #(.DIVISOR(VIRT_W)) u_scale_x2
    (
        .clk   (clk),
        .en    (pipe_en),
        .num   (nx2),
        .scale (win_w_reg),
        .quo   (qx2)
    );

    rrs_scale #(.DIVISOR(VIRT_H)) u_scale_y1
    (
        .clk   (clk),
        .en    (pipe_en),
        .num   (ny1),
        .scale (win_h_reg),
        .quo   (qy1)
    );

    rrs_scale #(.DIVISOR(VIRT_H)) u_scale_y2
    (
        .clk   (clk),
        .en    (pipe_en),
        .num   (ny2),
        .scale (win_h_reg),
        .quo   (qy2)
    );

    assign roww_next = ADDR_W'(row) * ADDR_W'(win_w_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_filled_reg <= filled;
            s1_thick_reg  <= thickness;
            s1_row_reg    <= row;
            s1_color_reg  <= color;
            s1_roww_reg   <= roww_next;
            s2_filled_reg <= s1_filled_reg;
            s2_thick_reg  <= s1_thick_reg;
            s2_row_reg    <= s1_row_reg;
            s2_color_reg  <= s1_color_reg;
            s2_roww_reg   <= s1_roww_reg;
            s3_filled_reg <= s2_filled_reg;
            s3_thick_reg  <= s2_thick_reg;
            s3_row_reg    <= s2_row_reg;
            s3_color_reg  <= s2_color_reg;
            s3_roww_reg   <= s2_roww_reg;
        end
    end

    // span selection for the row
    always_comb
    begin
        logic signed [SW-1:0] sx1, sx2, sy1, sy2, st, srow, bot, le, rs;
        logic top_band, bot_band, mid;

        sx1  = $signed(SW'(qx1));
        sx2  = $signed(SW'(qx2));
        sy1  = $signed(SW'(qy1));
        sy2  = $signed(SW'(qy2));
        st   = $signed(SW'(s3_thick_reg));
        srow = $signed(SW'(s3_row_reg));

        bot = sy2 - st + 1;
        if (bot < sy1)
            bot = sy1;
        le = sx1 + st - 1;
        if (le > sx2)
            le = sx2;
        rs = sx2 - st + 1;
        if (rs < sx1)
            rs = sx1;

        top_band = (srow >= sy1) && (srow <= sy1 + st - 1) && (srow <= sy2);
        bot_band = (srow >= bot) && (srow <= sy2);
        mid      = (srow >= sy1 + st) && (srow <= sy2 - st);

        hit_next = 1'b0;
        two_next = 1'b0;
        a_s = '0;
        a_e = '0;
        b_s = '0;
        b_e = '0;

        if (s3_filled_reg)
        begin
            if ((srow >= sy1) && (srow < sy2) && (sx1 < sx2))
            begin
                hit_next = 1'b1;
                a_s = sx1;
                a_e = sx2 - 1;
            end
        end
        else if (st > 0)
        begin
            priority if (top_band || bot_band)
            begin
                hit_next = 1'b1;
                a_s = sx1;
                a_e = sx2;
            end
            else if (mid)
            begin
                hit_next = 1'b1;
                two_next = 1'b1;
                a_s = sx1;
                a_e = le;
                b_s = rs;
                b_e = sx2;
            end
        end
    end

    // empty results carry all-zero fields
    assign a_start_next = hit_next ? sat_col(a_s) : '0;
    assign a_end_next   = hit_next ? sat_col(a_e) : '0;
    assign b_start_next = sat_col(b_s);
    assign b_end_next   = sat_col(b_e);
    assign a_addr_next  = hit_next ? s3_roww_reg + ADDR_W'(a_start_next) : '0;
    assign b_addr_next  = s3_roww_reg + ADDR_W'(b_start_next);
    assign color_next   = hit_next ? s3_color_reg : '0;

    // result register: holds one or two spans, shown one per transfer
    assign on_last = !two_reg || sel_reg;
    assign pipe_en = !out_valid_reg || (out_ready && on_last);
    assign in_ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            two_reg       <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= s3_valid_reg;
            two_reg       <= two_next;
            sel_reg       <= 1'b0;
        end
        else if (out_ready)
        begin
            sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            hit_reg     <= hit_next;
            a_start_reg <= a_start_next;
            a_end_reg   <= a_end_next;
            a_addr_reg  <= a_addr_next;
            b_start_reg <= b_start_next;
            b_end_reg   <= b_end_next;
            b_addr_reg  <= b_addr_next;
            color_reg   <= color_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign span_start    = sel_reg ? b_start_reg : a_start_reg;
    assign span_end      = sel_reg ? b_end_reg : a_end_reg;
    assign start_address = sel_reg ? b_addr_reg : a_addr_reg;
    assign span_valid    = hit_reg;
    assign pixel_color   = color_reg;
    assign last_span     = on_last;

endmodule

// ===== rtl/core/rrs_scale.sv =====
// (num * scale) / DIVISOR, truncating, over three pipeline stages:
// product, reciprocal estimate (low by at most one), then one correction step.
module rrs_scale
    import rrs_pkg::*;
#(
    parameter int DIVISOR = 1920
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [CFG_W-1:0]  scale,
    output logic [PROD_W-1:0] quo
);

    localparam int SHIFT = PROD_W + $clog2(DIVISOR);
    localparam int MW    = PROD_W + 1;
    localparam logic [63:0]       RECIP_FULL = (64'd1 << SHIFT) / 64'(DIVISOR);
    localparam logic [MW-1:0]     RECIP      = RECIP_FULL[MW-1:0];
    localparam logic [PROD_W-1:0] DIV_C      = PROD_W'(DIVISOR);

    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [PROD_W-1:0]    prod2_reg;
    logic [PROD_W-1:0]    est_reg;
    logic [PROD_W-1:0]    est_next;
    logic [PROD_W-1:0]    quo_reg;
    logic [PROD_W-1:0]    quo_next;
    logic [PROD_W+MW-1:0] mul_full;
    logic [PROD_W-1:0]    back;
    logic [PROD_W-1:0]    rem;

    assign prod_next = PROD_W'(PROD_W'(num) * PROD_W'(scale));

    assign mul_full = (PROD_W+MW)'(prod_reg) * (PROD_W+MW)'(RECIP);
    assign est_next = PROD_W'(mul_full >> SHIFT);

    // estimate never exceeds the true quotient, so the remainder is in [0, 2*DIVISOR)
    assign back     = PROD_W'(est_reg * DIV_C);
    assign rem      = prod2_reg - back;
    assign quo_next = est_reg + PROD_W'(rem >= DIV_C);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            prod2_reg <= prod_reg;
            est_reg   <= est_next;
            quo_reg   <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/core/rrs_checker.sv =====
module rrs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [12:0] span_start,
    input logic [12:0] span_end,
    input logic [24:0] start_address,
    input logic        span_valid,
    input logic [31:0] pixel_color,
    input logic        last_span
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !span_valid |-> last_span && span_start == 13'd0 && span_end == 13'd0
            && start_address == 25'd0 && pixel_color == 32'd0)
        else $error("empty result not marked last or not cleared");

    a_second_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_span |=> out_valid && span_valid && last_span)
        else $error("right span did not follow left span");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_valid |-> span_start <= span_end)
        else $error("span start beyond span end");

endmodule

bind rect_row_span_rasterizer_top rrs_checker u_rrs_checker (.*);

// ===== bench/tb_rect_row_span_rasterizer_top.sv =====
module tb_rect_row_span_rasterizer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rrs_pkg::*;

    localparam int VIRT_W         = 1920;
    localparam int VIRT_H         = 1080;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int NUM_PHASES     = 8;
    localparam int NUM_DIRECTED   = 20;

    typedef struct packed {
        logic [FIELD_W-1:0] rx;
        logic [FIELD_W-1:0] ry;
        logic [FIELD_W-1:0] rw;
        logic [FIELD_W-1:0] rh;
        logic               fill;
        logic [FIELD_W-1:0] thick;
        logic [FIELD_W-1:0] rrow;
        logic [COLOR_W-1:0] col;
    } span_req_t;

    typedef struct packed {
        logic [COL_W-1:0]   s;
        logic [COL_W-1:0]   e;
        logic [ADDR_W-1:0]  addr;
        logic               valid;
        logic [COLOR_W-1:0] pcolor;
        logic               last;
    } span_t;

    typedef struct packed {
        span_req_t q;
        logic      typed;
        span_t     want;
    } dir_row_t;

    localparam span_t NO_SPAN = '{s: '0, e: '0, addr: '0, valid: 1'b0, pcolor: '0, last: 1'b1};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [FIELD_W-1:0]   rect_x;
    logic [FIELD_W-1:0]   rect_y;
    logic [FIELD_W-1:0]   rect_w;
    logic [FIELD_W-1:0]   rect_h;
    logic                 filled;
    logic [FIELD_W-1:0]   thickness;
    logic [FIELD_W-1:0]   row;
    logic [COLOR_W-1:0]   color;
    logic                 out_valid;
    logic                 out_ready;
    logic [COL_W-1:0]     span_start;
    logic [COL_W-1:0]     span_end;
    logic [ADDR_W-1:0]    start_address;
    logic                 span_valid;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 last_span;

    // predictor copy of the window registers
    logic [CFG_W-1:0] win_w;
    logic [CFG_W-1:0] win_h;

    span_t    spans_due[$];
    dir_row_t directed[NUM_DIRECTED];
    logic     typed_on;
    span_t    typed_span;
    int       errors;
    int       stall_cycles;
    logic     burst_mode;
    logic     hold_go;
    logic     hold_done;

    int ph_w[NUM_PHASES] = '{1920, 1, 4096, 8191, 0, 640, 1280, 3000};
    int ph_h[NUM_PHASES] = '{1080, 1, 4096, 8191, 0, 480, 720, 17};
    int ph_n[NUM_PHASES] = '{130, 100, 130, 120, 70, 140, 120, 100};

    rect_row_span_rasterizer_top #(
        .VIRT_W(VIRT_W),
        .VIRT_H(VIRT_H)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rect_x(rect_x),
        .rect_y(rect_y),
        .rect_w(rect_w),
        .rect_h(rect_h),
        .filled(filled),
        .thickness(thickness),
        .row(row),
        .color(color),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .span_start(span_start),
        .span_end(span_end),
        .start_address(start_address),
        .span_valid(span_valid),
        .pixel_color(pixel_color),
        .last_span(last_span)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint scale(input longint v, input longint win, input longint virt);
        return (v * win) / virt;
    endfunction

    function automatic logic [COL_W-1:0] sat_col(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(COL_MAX))
            return COL_MAX;
        return v[COL_W-1:0];
    endfunction

    function automatic span_t make_span(input longint s, input longint e, input span_req_t q,
                                        input logic last);
        span_t      sp;
        logic [63:0] a;
        sp.s      = sat_col(s);
        sp.e      = sat_col(e);
        a         = longint'(q.rrow) * longint'(win_w) + longint'(sp.s);
        sp.addr   = a[ADDR_W-1:0];
        sp.valid  = 1'b1;
        sp.pcolor = q.col;
        sp.last   = last;
        return sp;
    endfunction

    // spans of one window row for one rectangle
    function automatic void rasterize_row(input span_req_t q);
        longint x1, x2, y1, y2, t, r, bot, le, rs;
        logic   top_band, bot_band;
        x1 = scale(longint'(q.rx), longint'(win_w), longint'(VIRT_W));
        x2 = scale(longint'(q.rx) + longint'(q.rw), longint'(win_w), longint'(VIRT_W));
        y1 = scale(longint'(q.ry), longint'(win_h), longint'(VIRT_H));
        y2 = scale(longint'(q.ry) + longint'(q.rh), longint'(win_h), longint'(VIRT_H));
        t  = longint'(q.thick);
        r  = longint'(q.rrow);
        if (q.fill) begin
            if (r >= y1 && r < y2 && x1 < x2)
                spans_due.push_back(make_span(x1, x2 - 1, q, 1'b1));
            else
                spans_due.push_back(NO_SPAN);
            return;
        end
        if (t > 0) begin
            bot = y2 - t + 1;
            if (bot < y1)
                bot = y1;
            top_band = r >= y1 && r <= y1 + t - 1 && r <= y2;
            bot_band = r >= bot && r <= y2;
            if (top_band || bot_band) begin
                spans_due.push_back(make_span(x1, x2, q, 1'b1));
                return;
            end
            if (r >= y1 + t && r <= y2 - t) begin
                // left and right edges clamped into the rectangle; they may overlap
                le = x1 + t - 1;
                rs = x2 - t + 1;
                if (le > x2)
                    le = x2;
                if (rs < x1)
                    rs = x1;
                spans_due.push_back(make_span(x1, le, q, 1'b0));
                spans_due.push_back(make_span(rs, x2, q, 1'b1));
                return;
            end
        end
        spans_due.push_back(NO_SPAN);
    endfunction

    function automatic span_req_t random_req();
        span_req_t q;
        longint    y1, y2, lo, hi;
        int        sel;
        q.col  = $urandom;
        q.fill = ($urandom_range(0, 99) < 40);
        sel = $urandom_range(0, 3);
        if (sel == 0) begin
            q.rx = FIELD_W'($urandom_range(0, 4095));
            q.ry = FIELD_W'($urandom_range(0, 4095));
            q.rw = FIELD_W'($urandom_range(0, 4095));
            q.rh = FIELD_W'($urandom_range(0, 4095));
        end
        else begin
            q.rx = FIELD_W'($urandom_range(0, 2000));
            q.ry = FIELD_W'($urandom_range(0, 1200));
            q.rw = FIELD_W'($urandom_range(0, 400));
            q.rh = FIELD_W'($urandom_range(0, 300));
        end
        sel = $urandom_range(0, 99);
        if (sel < 5)
            q.thick = '0;
        else if (sel < 70)
            q.thick = FIELD_W'($urandom_range(1, 6));
        else if (sel < 90)
            q.thick = FIELD_W'($urandom_range(1, 64));
        else
            q.thick = FIELD_W'($urandom_range(0, 4095));
        // aim most rows at the rectangle so bands and edges get hit
        y1 = scale(longint'(q.ry), longint'(win_h), longint'(VIRT_H));
        y2 = scale(longint'(q.ry) + longint'(q.rh), longint'(win_h), longint'(VIRT_H));
        lo = y1 - 2;
        hi = y2 + 2;
        if (lo < 0)
            lo = 0;
        if (lo > 4095)
            lo = 4095;
        if (hi > 4095)
            hi = 4095;
        if ($urandom_range(0, 9) < 2)
            q.rrow = FIELD_W'($urandom_range(0, 4095));
        else
            q.rrow = FIELD_W'($urandom_range(int'(lo), int'(hi)));
        return q;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // register writes, input transfers and output transfers, all sampled at the rising edge
    always @(posedge clk)
    begin
        span_t want;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == REG_WINDOW_WIDTH)
                    win_w = cfg_data;
                else if (cfg_index == REG_WINDOW_HEIGHT)
                    win_h = cfg_data;
            end
            if (in_valid && in_ready) begin
                if (typed_on)
                    spans_due.push_back(typed_span);
                else
                    rasterize_row('{rect_x, rect_y, rect_w, rect_h, filled, thickness, row,
                                    color});
            end
            if (out_valid && out_ready) begin
                if (spans_due.size() == 0) begin
                    $error("span transfer with nothing expected");
                    errors++;
                end
                else begin
                    want = spans_due.pop_front();
                    check_field("span_start", longint'(want.s), longint'(span_start));
                    check_field("span_end", longint'(want.e), longint'(span_end));
                    check_field("start_address", longint'(want.addr),
                                longint'(start_address));
                    check_field("span_valid", longint'(want.valid), longint'(span_valid));
                    check_field("pixel_color", longint'(want.pcolor), longint'(pixel_color));
                    check_field("last_span", longint'(want.last), longint'(last_span));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** rect_row_span_rasterizer_top: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // sink side: random back-pressure plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= burst_mode || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic send_req(input span_req_t q, input logic use_typed, input span_t typed);
        @(negedge clk);
        while (!burst_mode && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        rect_x     <= q.rx;
        rect_y     <= q.ry;
        rect_w     <= q.rw;
        rect_h     <= q.rh;
        filled     <= q.fill;
        thickness  <= q.thick;
        row        <= q.rrow;
        color      <= q.col;
        typed_on   <= use_typed;
        typed_span <= typed;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (spans_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        rect_x       = '0;
        rect_y       = '0;
        rect_w       = '0;
        rect_h       = '0;
        filled       = 1'b0;
        thickness    = '0;
        row          = '0;
        color        = '0;
        typed_on     = 1'b0;
        typed_span   = NO_SPAN;
        errors       = 0;
        stall_cycles = 0;
        burst_mode   = 1'b0;
        hold_go      = 1'b0;
        hold_done    = 1'b0;
        win_w        = WINDOW_WIDTH_RST;
        win_h        = WINDOW_HEIGHT_RST;

        // at reset size the scaling is one to one, so typed values read straight off the rect
        directed[0]  = '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 12'd0, 12'd0, 32'h1}, 1'b1, NO_SPAN};
        directed[1]  = '{'{12'd100, 12'd50, 12'd200, 12'd10, 1'b1, 12'd0, 12'd55, 32'hA5A5A5A5},
                         1'b1, '{13'd100, 13'd299, 25'd105700, 1'b1, 32'hA5A5A5A5, 1'b1}};
        directed[2]  = '{'{12'd100, 12'd50, 12'd200, 12'd10, 1'b1, 12'd0, 12'd60, 32'h5A5A5A5A},
                         1'b1, NO_SPAN};
        directed[3]  = '{'{12'd100, 12'd50, 12'd200, 12'd100, 1'b0, 12'd0, 12'd60, 32'h3}, 1'b1,
                         NO_SPAN};
        directed[4]  = '{'{12'd100, 12'd50, 12'd200, 12'd100, 1'b0, 12'd3, 12'd50, 32'h12345678},
                         1'b1, '{13'd100, 13'd300, 25'd96100, 1'b1, 32'h12345678, 1'b1}};
        directed[5]  = '{'{12'd100, 12'd50, 12'd200, 12'd100, 1'b0, 12'd3, 12'd52, 32'h4}, 1'b0,
                         NO_SPAN};
        directed[6]  = '{'{12'd100, 12'd50, 12'd200, 12'd100, 1'b0, 12'd3, 12'd53, 32'h5}, 1'b0,
                         NO_SPAN};
        directed[7]  = '{'{12'd100, 12'd50, 12'd200, 12'd100, 1'b0, 12'd3, 12'd147, 32'h6}, 1'b0,
                         NO_SPAN};
        directed[8]  = '{'{12'd100, 12'd50, 12'd200, 12'd100, 1'b0, 12'd3, 12'd148, 32'h7}, 1'b0,
                         NO_SPAN};
        directed[9]  = '{'{12'd100, 12'd50, 12'd200, 12'd100, 1'b0, 12'd3, 12'd150, 32'h8}, 1'b0,
                         NO_SPAN};
        directed[10] = '{'{12'd100, 12'd50, 12'd200, 12'd100, 1'b0, 12'd3, 12'd151, 32'h9}, 1'b1,
                         NO_SPAN};
        directed[11] = '{'{12'd100, 12'd0, 12'd4, 12'd100, 1'b0, 12'd5, 12'd50, 32'hA}, 1'b0,
                         NO_SPAN};
        directed[12] = '{'{12'd0, 12'd0, 12'd50, 12'd4, 1'b0, 12'd10, 12'd3, 32'hB}, 1'b0, NO_SPAN};
        directed[13] = '{'{12'd0, 12'd0, 12'd50, 12'd4, 1'b0, 12'd10, 12'd5, 32'hC}, 1'b1, NO_SPAN};
        directed[14] = '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 12'd4095, 12'd4095,
                           32'hFFFFFFFF}, 1'b0, NO_SPAN};
        directed[15] = '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 12'd4095, 12'd4095,
                           32'hFFFFFFFF}, 1'b1,
                         '{13'd4095, 13'd8190, 25'd7866495, 1'b1, 32'hFFFFFFFF, 1'b1}};
        // row below the window is still drawn
        directed[16] = '{'{12'd0, 12'd1000, 12'd1920, 12'd3000, 1'b1, 12'd0, 12'd2500, 32'hD},
                         1'b1, '{13'd0, 13'd1919, 25'd4800000, 1'b1, 32'hD, 1'b1}};
        directed[17] = '{'{12'd10, 12'd10, 12'd10, 12'd0, 1'b1, 12'd0, 12'd10, 32'hE}, 1'b1,
                         NO_SPAN};
        directed[18] = '{'{12'd500, 12'd0, 12'd0, 12'd50, 1'b0, 12'd2, 12'd10, 32'hF}, 1'b0,
                         NO_SPAN};
        directed[19] = '{'{12'd0, 12'd0, 12'd4095, 12'd1, 1'b1, 12'd0, 12'd0, 32'h0}, 1'b1,
                         '{13'd0, 13'd4094, 25'd0, 1'b1, 32'h0, 1'b1}};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_req(directed[i].q, directed[i].typed, directed[i].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            @(negedge clk);
            in_valid <= 1'b0;
            wait_drained();
            write_reg(REG_WINDOW_WIDTH, ph_w[p]);
            write_reg(REG_WINDOW_HEIGHT, ph_h[p]);
            burst_mode = (p == 2);
            for (int i = 0; i < ph_n[p]; i++) begin
                if (p == 0 && i == 30)
                    hold_go = 1'b1;
                send_req(random_req(), 1'b0, NO_SPAN);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("** rect_row_span_rasterizer_top: PASSED **");
        else
            $display("** rect_row_span_rasterizer_top: FAILED **");
        $finish;
    end

endmodule
